// ----- src/bp_pkg.sv -----
// ----------------------------------------------------------------------------
// bp_pkg
// Shared types and constants for the LSB-first bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package bp_pkg;

  localparam int unsigned MAX_BYTES_DEF = 4096;
  localparam logic [12:0] CAP_RST       = 13'd4096;
  localparam int unsigned Q_DEPTH       = 2;
  localparam int unsigned Q_AW          = $clog2(Q_DEPTH);
  localparam logic [5:0]  MAX_FIELD     = 6'd32;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_WIDTH = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_PAD   = 1'b1
  } req_t;

  typedef struct packed {
    req_t        req_type;
    logic [31:0] data_value;
    logic [5:0]  bit_count;
  } in_item_t;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  data_byte;
    status_t     status;
    logic        last;
    logic [15:0] bits_written;
  } out_item_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    logic [31:0] bytes;
    logic [2:0]  nbytes;
    status_t     status;
    logic [15:0] bits_written;
  } job_t;

endpackage

`default_nettype wire

// ----- src/bp_front.sv -----
// ----------------------------------------------------------------------------
// bp_front
// Accepts items, checks them and advances the bit position and open byte.
// ----------------------------------------------------------------------------
`default_nettype none

module bp_front import bp_pkg::*; #(
  parameter int unsigned MAX_BYTES = MAX_BYTES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  input  wire logic      cfg_valid,
  input  wire logic [12:0] cfg_data,
  input  wire logic      q_full,
  output logic           push,
  output job_t           push_job
);

  localparam logic [16:0] MAX_B = 17'(MAX_BYTES);

  function automatic logic [15:0] cap_limit(input logic [12:0] cap);
    logic [16:0] c17;
    logic [16:0] cl;
    c17 = {4'b0000, cap};
    cl  = (c17 > MAX_B) ? MAX_B : c17;
    return {cl[12:0], 3'b000};
  endfunction

  logic [7:0]  partial_r, partial_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] limit_r;

  logic [2:0]  offset;
  logic        is_pad;
  logic [5:0]  cnt;
  logic        width_err, full_err, ok;
  logic [15:0] room;
  logic [31:0] value, masked;
  logic [32:0] mask33;
  logic [39:0] acc;
  logic [6:0]  total;
  logic [2:0]  nbytes;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    offset    = pos_r[2:0];
    is_pad    = (in_data.req_type == REQ_PAD);
    cnt       = is_pad ? ((offset == 3'd0) ? 6'd0 : (6'd8 - {3'b000, offset}))
                       : in_data.bit_count;
    width_err = !is_pad && (in_data.bit_count > MAX_FIELD);
    room      = limit_r - pos_r;
    full_err  = (pos_r > limit_r) || ({10'b0, cnt} > room);
    ok        = !width_err && !full_err;
    value     = is_pad ? 32'd0 : in_data.data_value;
    mask33    = (33'd1 << cnt) - 33'd1;
    masked    = value & mask33[31:0];
    acc       = {32'd0, partial_r} | ({8'd0, masked} << offset);
    total     = {4'b0000, offset} + {1'b0, cnt};
    nbytes    = total[5:3];

    case (nbytes)
      3'd0:    partial_nxt = acc[7:0];
      3'd1:    partial_nxt = acc[15:8];
      3'd2:    partial_nxt = acc[23:16];
      3'd3:    partial_nxt = acc[31:24];
      default: partial_nxt = acc[39:32];
    endcase
    pos_nxt = pos_r + {10'b0, cnt};

    push_job.bytes        = acc[31:0];
    push_job.nbytes       = ok ? nbytes : 3'd0;
    push_job.status       = width_err ? ST_WIDTH : (full_err ? ST_FULL : ST_OK);
    push_job.bits_written = ok ? pos_nxt : pos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= 8'd0;
      pos_r     <= 16'd0;
      limit_r   <= cap_limit(CAP_RST);
    end else if (cfg_valid) begin
      // restart the stream on a capacity write
      partial_r <= 8'd0;
      pos_r     <= 16'd0;
      limit_r   <= cap_limit(cfg_data);
    end else if (push && ok) begin
      partial_r <= partial_nxt;
      pos_r     <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/bp_queue.sv -----
// ----------------------------------------------------------------------------
// bp_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module bp_queue import bp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output logic      full,
  output logic      empty,
  output job_t      head
);

  job_t               mem_r [Q_DEPTH];
  logic [Q_AW-1:0]    wr_r, rd_r;
  logic [Q_AW:0]      cnt_r;

  assign full  = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == (Q_AW)'(Q_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == (Q_AW)'(Q_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/bp_back.sv -----
// ----------------------------------------------------------------------------
// bp_back
// Drains queued jobs into the output register, one result per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bp_back import bp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire job_t      head,
  input  wire logic      q_empty,
  output logic           pop,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic       out_valid_r;
  out_item_t  out_r, res;
  logic [1:0] idx_r;
  logic       load, is_last;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    load    = !q_empty && (!out_valid_r || out_ready);
    is_last = (head.nbytes == 3'd0) || ({1'b0, idx_r} + 3'd1 == head.nbytes);
    pop     = load && is_last;

    res.byte_valid   = (head.nbytes != 3'd0);
    res.data_byte    = res.byte_valid ? head.bytes[{idx_r, 3'b000} +: 8] : 8'd0;
    res.status       = head.status;
    res.last         = is_last;
    res.bits_written = head.bits_written;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= is_last ? 2'd0 : idx_r + 2'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/lsb_first_bit_packer_top.sv -----
// ----------------------------------------------------------------------------
// lsb_first_bit_packer_top
// Packs 0..32-bit fields into a byte stream, least significant bit first.
// ----------------------------------------------------------------------------
// A new item is taken every cycle as long as the two-entry job queue has
// room. Each item yields one result per completed byte (up to four), or a
// single result with byte_valid low when no byte completes or the item is
// rejected; results leave one per cycle from a registered output while
// out_ready is high, so the output drain sets the sustained rate. An
// accepted item is written to the job queue and then loaded into the
// output register. A capacity write (cfg_valid, always ready) restarts the
// stream at bit position zero and must only be issued while no results are
// outstanding.
`default_nettype none

module lsb_first_bit_packer_top import bp_pkg::*; #(
  parameter int unsigned MAX_BYTES = MAX_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [12:0] cfg_data
);

  logic q_full, q_empty, push, pop;
  job_t push_job, head;

  // configuration is never stalled
  assign cfg_ready = 1'b1;

  // front: check the item, advance position and open byte
  bp_front #(.MAX_BYTES(MAX_BYTES)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // hold classified jobs so the front keeps going while bytes drain
  bp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .full    (q_full),
    .empty   (q_empty),
    .head    (head)
  );

  // back: emit one result per cycle while out_ready is high, drop the job after its last result
  bp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_empty  (q_empty),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ----- src/bp_checker.sv -----
// ----------------------------------------------------------------------------
// bp_checker
// Port-level checks for the LSB-first bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

module bp_checker import bp_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire out_item_t   out_data
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a result without a byte is the only result of its item
  a_nobyte_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.byte_valid |-> out_data.last)
    else $error("empty result not marked last");

  // rejected items carry no byte
  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |->
      !out_data.byte_valid && (out_data.data_byte == 8'd0))
    else $error("rejected item carries a byte");

  // bytes of one item follow without a gap and share the bit position
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last |=>
      out_valid && (out_data.bits_written == $past(out_data.bits_written)))
    else $error("byte burst broken");

endmodule

bind lsb_first_bit_packer_top bp_checker u_bp_checker (.*);

`default_nettype wire
